// ===== rtl/pixel_format_converter_assert.svh =====
// ----------------------------------------------------------------------------
// pixel format converter assertion macros
// wrappers that expand to concurrent assertions in simulation and to nothing
// in synthesis
// ----------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("pfc check failed");

// antecedent implies consequent in the next cycle
`define PFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("pfc check failed");

`else

`define PFC_ASSERT_SAME(label, ante, cons)
`define PFC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types, format codes and helpers for the pixel format converter
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int CHAN_W  = 8;
    localparam int FMT_W   = 3;
    localparam int SUM_W   = 10;
    localparam int CFG_IDX_W = 1;

    // reciprocal of three: (sum * 683) >> 11 is exact for sum <= 765
    localparam int RECIP_W     = 10;
    localparam int RECIP_SHIFT = 11;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(683);

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = '1;

    typedef enum logic [FMT_W-1:0] {
        FMT_GRAY       = 3'd1,
        FMT_GRAY_ALPHA = 3'd2,
        FMT_RGB        = 3'd3,
        FMT_RGBA       = 3'd4
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_FORMAT = 1'b0,
        CFG_TARGET_FORMAT = 1'b1
    } t_cfg_idx;

    // unpacked pixel after stage one
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [SUM_W-1:0]  sum;
    } t_s1;

    // pixel with gray level after stage two
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] gray;
        logic [SUM_W-1:0]  sum;
    } t_s2;

    function automatic logic fmt_ok(input logic [FMT_W-1:0] fmt);
        return (fmt == FMT_GRAY) || (fmt == FMT_GRAY_ALPHA) ||
               (fmt == FMT_RGB) || (fmt == FMT_RGBA);
    endfunction

endpackage

// ===== rtl/pixel_format_converter.sv =====
// ----------------------------------------------------------------------------
// pixel_format_converter
// converts 8-bit-per-channel pixels between gray, gray alpha, rgb and rgba
// ----------------------------------------------------------------------------
// Takes one pixel per clock while o_stall is low and returns one converted
// pixel per input pixel, in order, after it passes the register stages.
// The three register stages are: unpack (channel mapping, alpha default of 255,
// r+g+b sum), gray (floor of the sum over three, done as a 10-bit reciprocal
// multiply), and pack (placement per target format, unused channels zero).
// Formats are channel counts: 1 gray, 2 gray alpha, 3 rgb, 4 rgba; any other
// code in either format register gives an all-zero pixel. Format registers
// are written through the cfg port (index 0 source, index 1 target, reset rgb
// to rgba), which is always ready; write them only while no pixel is in flight.
// Each stage moves whenever it is empty or the one after it moves, so bubbles
// are squeezed out and a stalled output holds without losing or repeating a
// beat.
// ----------------------------------------------------------------------------
module pixel_format_converter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pfc_pkg::CHAN_W-1:0]      i_in_chan0,
    input  logic [pfc_pkg::CHAN_W-1:0]      i_in_chan1,
    input  logic [pfc_pkg::CHAN_W-1:0]      i_in_chan2,
    input  logic [pfc_pkg::CHAN_W-1:0]      i_in_chan3,
    // pixel output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pfc_pkg::CHAN_W-1:0]      o_out_chan0,
    output logic [pfc_pkg::CHAN_W-1:0]      o_out_chan1,
    output logic [pfc_pkg::CHAN_W-1:0]      o_out_chan2,
    output logic [pfc_pkg::CHAN_W-1:0]      o_out_chan3,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pfc_pkg::FMT_W-1:0]       i_cfg_data
);
    import pfc_pkg::*;

    `include "pixel_format_converter_assert.svh"

    // format registers
    logic [FMT_W-1:0] r_src_fmt;
    logic [FMT_W-1:0] r_tgt_fmt;

    // stage valid bits
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;

    // a stage may load when it is empty or its content moves on
    logic adv1, adv2, adv3;

    t_s1 s1;
    t_s2 s2;

    // sum check for the gray stage
    logic [SUM_W-1:0] gray_x3;
    logic             div_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_RGB;
            r_tgt_fmt <= FMT_RGBA;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE_FORMAT: r_src_fmt <= i_cfg_data;
                CFG_TARGET_FORMAT: r_tgt_fmt <= i_cfg_data;
                default:           r_src_fmt <= r_src_fmt;
            endcase
        end
    end

    // ready chain from the output back to the input
    assign adv3    = !r_v3 || !i_stall;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_comb begin
        n_v1 = adv1 ? i_valid : r_v1;
        n_v2 = adv2 ? r_v1    : r_v2;
        n_v3 = adv3 ? r_v2    : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    pfc_unpack u_unpack (
        .i_clk     (i_clk),
        .i_load    (adv1),
        .i_src_fmt (r_src_fmt),
        .i_chan0   (i_in_chan0),
        .i_chan1   (i_in_chan1),
        .i_chan2   (i_in_chan2),
        .i_chan3   (i_in_chan3),
        .o_s1      (s1)
    );

    pfc_div3 u_div3 (
        .i_clk  (i_clk),
        .i_load (adv2),
        .i_s1   (s1),
        .o_s2   (s2)
    );

    pfc_pack u_pack (
        .i_clk     (i_clk),
        .i_load    (adv3),
        .i_src_fmt (r_src_fmt),
        .i_tgt_fmt (r_tgt_fmt),
        .i_s2      (s2),
        .o_chan0   (o_out_chan0),
        .o_chan1   (o_out_chan1),
        .o_chan2   (o_out_chan2),
        .o_chan3   (o_out_chan3)
    );

    assign o_valid = r_v3;

    // gray must satisfy 3*gray <= sum < 3*gray + 3
    assign gray_x3 = SUM_W'(s2.gray) * SUM_W'(3);
    assign div_ok  = (gray_x3 <= s2.sum) && ((s2.sum - gray_x3) < SUM_W'(3));

    `PFC_ASSERT_SAME(a_gray_quotient, r_v2, div_ok)
    `PFC_ASSERT_NEXT(a_out_beat_kept, r_v3 && i_stall, r_v3)
    `PFC_ASSERT_SAME(a_no_take_when_full, r_v1 && r_v2 && r_v3 && i_stall, o_stall)
    `PFC_ASSERT_NEXT(a_bubble_fills, !r_v2 && r_v1, r_v2)

endmodule

// ===== rtl/pfc_unpack.sv =====
// ----------------------------------------------------------------------------
// pfc_unpack
// stage one: maps source channels to red, green, blue, alpha and sums color
// ----------------------------------------------------------------------------
module pfc_unpack (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [pfc_pkg::FMT_W-1:0]   i_src_fmt,
    input  logic [pfc_pkg::CHAN_W-1:0]  i_chan0,
    input  logic [pfc_pkg::CHAN_W-1:0]  i_chan1,
    input  logic [pfc_pkg::CHAN_W-1:0]  i_chan2,
    input  logic [pfc_pkg::CHAN_W-1:0]  i_chan3,
    output pfc_pkg::t_s1                o_s1
);
    import pfc_pkg::*;

    t_s1 r_s1;
    t_s1 n_s1;

    always_comb begin
        n_s1 = r_s1;
        unique case (i_src_fmt) inside
            FMT_GRAY, FMT_GRAY_ALPHA: begin
                n_s1.red   = i_chan0;
                n_s1.green = i_chan0;
                n_s1.blue  = i_chan0;
                n_s1.alpha = (i_src_fmt == FMT_GRAY_ALPHA) ? i_chan1 : ALPHA_OPAQUE;
            end
            default: begin
                // color source, also covers bad codes (zeroed at the output)
                n_s1.red   = i_chan0;
                n_s1.green = i_chan1;
                n_s1.blue  = i_chan2;
                n_s1.alpha = (i_src_fmt == FMT_RGBA) ? i_chan3 : ALPHA_OPAQUE;
            end
        endcase
        n_s1.sum = SUM_W'(n_s1.red) + SUM_W'(n_s1.green) + SUM_W'(n_s1.blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== rtl/pfc_div3.sv =====
// ----------------------------------------------------------------------------
// pfc_div3
// stage two: gray level as floor(sum / 3) by reciprocal multiply
// ----------------------------------------------------------------------------
module pfc_div3 (
    input  logic         i_clk,
    input  logic         i_load,
    input  pfc_pkg::t_s1 i_s1,
    output pfc_pkg::t_s2 o_s2
);
    import pfc_pkg::*;

    t_s2                r_s2;
    t_s2                n_s2;
    logic [PROD_W-1:0]  prod;

    always_comb begin
        prod        = PROD_W'(i_s1.sum) * PROD_W'(RECIP3);
        n_s2.red    = i_s1.red;
        n_s2.green  = i_s1.green;
        n_s2.blue   = i_s1.blue;
        n_s2.alpha  = i_s1.alpha;
        n_s2.sum    = i_s1.sum;
        n_s2.gray   = prod[RECIP_SHIFT +: CHAN_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

// ===== rtl/pfc_pack.sv =====
// ----------------------------------------------------------------------------
// pfc_pack
// stage three: places channels for the target format, zeros unused ones
// ----------------------------------------------------------------------------
module pfc_pack (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [pfc_pkg::FMT_W-1:0]   i_src_fmt,
    input  logic [pfc_pkg::FMT_W-1:0]   i_tgt_fmt,
    input  pfc_pkg::t_s2                i_s2,
    output logic [pfc_pkg::CHAN_W-1:0]  o_chan0,
    output logic [pfc_pkg::CHAN_W-1:0]  o_chan1,
    output logic [pfc_pkg::CHAN_W-1:0]  o_chan2,
    output logic [pfc_pkg::CHAN_W-1:0]  o_chan3
);
    import pfc_pkg::*;

    logic [CHAN_W-1:0] r_chan0, r_chan1, r_chan2, r_chan3;
    logic [CHAN_W-1:0] n_chan0, n_chan1, n_chan2, n_chan3;

    always_comb begin
        n_chan0 = '0;
        n_chan1 = '0;
        n_chan2 = '0;
        n_chan3 = '0;
        if (fmt_ok(i_src_fmt)) begin
            unique case (i_tgt_fmt)
                FMT_GRAY: begin
                    n_chan0 = i_s2.gray;
                end
                FMT_GRAY_ALPHA: begin
                    n_chan0 = i_s2.gray;
                    n_chan1 = i_s2.alpha;
                end
                FMT_RGB: begin
                    n_chan0 = i_s2.red;
                    n_chan1 = i_s2.green;
                    n_chan2 = i_s2.blue;
                end
                FMT_RGBA: begin
                    n_chan0 = i_s2.red;
                    n_chan1 = i_s2.green;
                    n_chan2 = i_s2.blue;
                    n_chan3 = i_s2.alpha;
                end
                default: begin
                    n_chan0 = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chan0 <= n_chan0;
            r_chan1 <= n_chan1;
            r_chan2 <= n_chan2;
            r_chan3 <= n_chan3;
        end
    end

    assign o_chan0 = r_chan0;
    assign o_chan1 = r_chan1;
    assign o_chan2 = r_chan2;
    assign o_chan3 = r_chan3;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the pixel format converter: every accepted pixel is
// converted by a behavioral predictor under the current format registers and
// queued; each output beat is compared channel by channel, in order, while
// both sides idle at random and the output is held off for a long stretch
// ----------------------------------------------------------------------------
module tb;

    import pfc_pkg::*;

    // format codes outside the legal channel counts
    localparam logic [FMT_W-1:0] FMT_CODE_ZERO  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_CODE_FIVE  = 3'd5;
    localparam logic [FMT_W-1:0] FMT_CODE_SIX   = 3'd6;
    localparam logic [FMT_W-1:0] FMT_CODE_SEVEN = 3'd7;

    localparam int PIPE_DEPTH  = 3;
    localparam int MAX_GAP     = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CHAN_W-1:0] ch0;
        logic [CHAN_W-1:0] ch1;
        logic [CHAN_W-1:0] ch2;
        logic [CHAN_W-1:0] ch3;
    } t_pixel;

    // clock, reset and all block inputs start at known values
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [CHAN_W-1:0] i_in_chan0 = '0;
    logic [CHAN_W-1:0] i_in_chan1 = '0;
    logic [CHAN_W-1:0] i_in_chan2 = '0;
    logic [CHAN_W-1:0] i_in_chan3 = '0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FMT_W-1:0] i_cfg_data = '0;

    logic o_stall;
    logic o_valid;
    logic [CHAN_W-1:0] o_out_chan0;
    logic [CHAN_W-1:0] o_out_chan1;
    logic [CHAN_W-1:0] o_out_chan2;
    logic [CHAN_W-1:0] o_out_chan3;
    logic o_cfg_ready;

    // shadow of the format registers, reset values rgb to rgba
    logic [FMT_W-1:0] src_fmt = FMT_RGB;
    logic [FMT_W-1:0] tgt_fmt = FMT_RGBA;

    // converted pixels still owed by the block, oldest first
    t_pixel expected_pixels[$];

    // idle controls, written with nonblocking assignments only
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    logic rx_hold = 1'b0;
    int rx_gap = 0;

    int err_count = 0;
    int cycles = 0;

    pixel_format_converter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_chan0  (i_in_chan0),
        .i_in_chan1  (i_in_chan1),
        .i_in_chan2  (i_in_chan2),
        .i_in_chan3  (i_in_chan3),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_chan0 (o_out_chan0),
        .o_out_chan1 (o_out_chan1),
        .o_out_chan2 (o_out_chan2),
        .o_out_chan3 (o_out_chan3),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycles, expected_pixels.size());
            $display("** pixel_format_converter: FAILED **");
            $finish;
        end
    end

    // behavioral conversion of one pixel between channel-count formats
    function automatic t_pixel convert_pixel(input logic [FMT_W-1:0] src,
                                             input logic [FMT_W-1:0] tgt,
                                             input t_pixel px);
        t_pixel res;
        logic [CHAN_W-1:0] red, grn, blu, gry, alp;
        int sum;
        res = '0;
        // any illegal code in either register gives an all-zero pixel
        if (src >= FMT_GRAY && src <= FMT_RGBA && tgt >= FMT_GRAY && tgt <= FMT_RGBA) begin
            if (src == FMT_GRAY || src == FMT_GRAY_ALPHA) begin
                // gray fans out to all three colors
                red = px.ch0;
                grn = px.ch0;
                blu = px.ch0;
                gry = px.ch0;
                alp = (src == FMT_GRAY_ALPHA) ? px.ch1 : ALPHA_OPAQUE;
            end else begin
                red = px.ch0;
                grn = px.ch1;
                blu = px.ch2;
                sum = int'(px.ch0) + int'(px.ch1) + int'(px.ch2);
                gry = CHAN_W'(sum / 3);
                alp = (src == FMT_RGBA) ? px.ch3 : ALPHA_OPAQUE;
            end
            case (tgt)
                FMT_GRAY: begin
                    res.ch0 = gry;
                end
                FMT_GRAY_ALPHA: begin
                    res.ch0 = gry;
                    res.ch1 = alp;
                end
                FMT_RGB: begin
                    res.ch0 = red;
                    res.ch1 = grn;
                    res.ch2 = blu;
                end
                default: begin
                    res.ch0 = red;
                    res.ch1 = grn;
                    res.ch2 = blu;
                    res.ch3 = alp;
                end
            endcase
        end
        return res;
    endfunction

    // channel value biased toward the extremes
    function automatic logic [CHAN_W-1:0] rand_chan();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly legal format codes, now and then any 3-bit code
    function automatic logic [FMT_W-1:0] rand_fmt();
        if ($urandom_range(0, 7) == 0)
            return FMT_W'($urandom_range(0, 7));
        return FMT_W'($urandom_range(FMT_GRAY, FMT_RGBA));
    endfunction

    // sender: optional gap, then offer the beat until it is taken
    task automatic send_pixel(input logic [CHAN_W-1:0] c0, input logic [CHAN_W-1:0] c1,
                              input logic [CHAN_W-1:0] c2, input logic [CHAN_W-1:0] c3);
        int gap;
        t_pixel px;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        px = {c0, c1, c2, c3};
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_chan0 <= c0;
        i_in_chan1 <= c1;
        i_in_chan2 <= c2;
        i_in_chan3 <= c3;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        // beat taken: predict under the formats in force right now
        expected_pixels.push_back(convert_pixel(src_fmt, tgt_fmt, px));
    endtask

    task automatic send_random_pixel();
        send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endtask

    // stop offering and wait until every owed beat has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // one register write; valid is left high for a following write
    task automatic write_reg(input t_cfg_idx idx, input logic [FMT_W-1:0] code);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= code;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx == CFG_SOURCE_FORMAT)
            src_fmt = code;
        else
            tgt_fmt = code;
    endtask

    // formats change only with the pipeline empty
    task automatic set_formats(input logic [FMT_W-1:0] src, input logic [FMT_W-1:0] tgt);
        wait_drained();
        write_reg(CFG_SOURCE_FORMAT, src);
        write_reg(CFG_TARGET_FORMAT, tgt);
        i_cfg_valid <= 1'b0;
    endtask

    // new idle mix for the next phase, sometimes none at all
    task automatic shuffle_idling();
        tx_idle_on <= ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
    endtask

    // receiver: after each taken beat draw a random stall;
    // the long hold overrides everything
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap <= 0;
        end else if (rx_hold) begin
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            rx_gap <= gap;
            i_stall <= (gap != 0);
        end else if (rx_gap > 1) begin
            rx_gap <= rx_gap - 1;
            i_stall <= 1'b1;
        end else begin
            rx_gap <= 0;
            i_stall <= 1'b0;
        end
    end

    // checker: every taken output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_pixel exp_px;
        t_pixel got_px;
        if (i_rst_n && o_valid && !i_stall) begin
            got_px = {o_out_chan0, o_out_chan1, o_out_chan2, o_out_chan3};
            if (expected_pixels.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected beat %h %h %h %h at cycle %0d",
                             got_px.ch0, got_px.ch1, got_px.ch2, got_px.ch3, cycles);
            end else begin
                exp_px = expected_pixels.pop_front();
                if (got_px.ch0 !== exp_px.ch0 || got_px.ch1 !== exp_px.ch1 ||
                    got_px.ch2 !== exp_px.ch2 || got_px.ch3 !== exp_px.ch3) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("mismatch at cycle %0d: exp %h %h %h %h got %h %h %h %h",
                                 cycles, exp_px.ch0, exp_px.ch1, exp_px.ch2, exp_px.ch3,
                                 got_px.ch0, got_px.ch1, got_px.ch2, got_px.ch3);
                end
            end
        end
    end

    // reset formats rgb to rgba, channel extremes and alternating bits
    task automatic test_default_formats();
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00, 8'h80);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'h01);
        send_pixel(8'h00, 8'h00, 8'hFF, 8'hFE);
        send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
        send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    endtask

    // floor of the average at the edges of the sum range
    task automatic test_gray_rounding();
        set_formats(FMT_RGB, FMT_GRAY);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFE, 8'h00);
        send_pixel(8'h01, 8'h01, 8'h00, 8'hFF);
        send_pixel(8'h01, 8'h01, 8'h01, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h02, 8'h00);
    endtask

    // alpha carried, filled as opaque, dropped, and same-format passthrough
    task automatic test_alpha_handling();
        set_formats(FMT_RGBA, FMT_GRAY_ALPHA);
        send_pixel(8'h0A, 8'h14, 8'h1E, 8'h7F);
        set_formats(FMT_GRAY, FMT_RGBA);
        send_pixel(8'h3C, 8'h11, 8'h22, 8'h33);
        set_formats(FMT_GRAY_ALPHA, FMT_RGBA);
        send_pixel(8'hC3, 8'h5A, 8'hFF, 8'hFF);
        set_formats(FMT_RGBA, FMT_RGB);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        set_formats(FMT_GRAY_ALPHA, FMT_GRAY_ALPHA);
        send_pixel(8'h9D, 8'h42, 8'hFF, 8'hFF);
    endtask

    // any illegal code on either side zeroes the whole pixel
    task automatic test_invalid_codes();
        set_formats(FMT_CODE_ZERO, FMT_RGBA);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        set_formats(FMT_CODE_FIVE, FMT_GRAY);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        set_formats(FMT_RGB, FMT_CODE_SEVEN);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        set_formats(FMT_GRAY_ALPHA, FMT_CODE_SIX);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    // every legal source and target pair with random pixels
    task automatic test_format_sweep();
        for (int s = FMT_GRAY; s <= FMT_RGBA; s++) begin
            for (int t = FMT_GRAY; t <= FMT_RGBA; t++) begin
                set_formats(FMT_W'(s), FMT_W'(t));
                shuffle_idling();
                repeat (20) send_random_pixel();
            end
        end
    endtask

    // short phases under random settings, illegal codes now and then
    task automatic test_random_settings();
        repeat (38) begin
            set_formats(rand_fmt(), rand_fmt());
            shuffle_idling();
            repeat ($urandom_range(1, 12)) send_random_pixel();
        end
    endtask

    // output held off for a long stretch while the sender keeps offering,
    // so the pipeline fills and the input stall comes up
    task automatic test_output_backpressure();
        set_formats(FMT_W'($urandom_range(FMT_GRAY, FMT_RGBA)),
                    FMT_W'($urandom_range(FMT_GRAY, FMT_RGBA)));
        tx_idle_on <= 1'b0;
        rx_idle_on <= 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (60) send_random_pixel();
    endtask

    initial begin
        // synchronous reset held low, then released on a clock edge
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_formats();
        test_gray_rounding();
        test_alpha_handling();
        test_invalid_codes();
        test_format_sweep();
        test_random_settings();
        test_output_backpressure();

        // let everything owed come out, then a short tail
        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (err_count == 0 && expected_pixels.size() == 0) begin
            $display("** pixel_format_converter: PASSED **");
        end else begin
            $display("** pixel_format_converter: FAILED **");
        end
        $finish;
    end

endmodule
